[src/itsmm_pkg.sv]
// ============================================================================
// itsmm_pkg
// Shared widths, operation and status codes, state and command types for the
// integer table with exchange sort and min/max.
// ============================================================================
`default_nettype none

package itsmm_pkg;

   localparam int WORD_W = 32;
   localparam int LEN_W  = 5;
   localparam int IDX_W  = 8;
   localparam int FUNC_W = 3;
   localparam int STAT_W = 2;

   localparam logic [LEN_W-1:0] LEN_RESET = 5'd16;

   localparam logic [FUNC_W-1:0] FN_APPEND = 3'd0;
   localparam logic [FUNC_W-1:0] FN_WRITE  = 3'd1;
   localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd2;
   localparam logic [FUNC_W-1:0] FN_SORT   = 3'd3;
   localparam logic [FUNC_W-1:0] FN_READ   = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_SORT_I,
      S_SORT_IW,
      S_SORT_J,
      S_SORT_STORE,
      S_SCAN,
      S_SCAN_LAST,
      S_DONE
   } state_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_CLEAR,
      CMD_LOAD,
      CMD_EXEC,
      CMD_SORT_I,
      CMD_SORT_IW,
      CMD_SORT_J,
      CMD_SORT_STORE,
      CMD_SCAN,
      CMD_SCAN_LAST
   } dp_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic sort_go;
      logic j_done;
      logic i_done;
      logic scan_last;
   } dp_status_type;

endpackage

`default_nettype wire

[src/itsmm_ram.sv]
// ============================================================================
// itsmm_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module itsmm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[src/itsmm_ctrl.sv]
// ============================================================================
// itsmm_ctrl
// Sequencer: clearing pass, operation, exchange sort loops, min/max scan.
// ============================================================================
`default_nettype none

module itsmm_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire itsmm_pkg::dp_status_type dp_status,
   output      itsmm_pkg::dp_cmd_type   dp_cmd,
   output      logic                    busy,
   output      logic                    rsp_strobe
);

   import itsmm_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (dp_status.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = dp_status.sort_go ? S_SORT_I : S_SCAN;
         end
         S_SORT_I:  state_in = S_SORT_IW;
         S_SORT_IW: state_in = S_SORT_J;
         S_SORT_J: begin
            if (dp_status.j_done) state_in = S_SORT_STORE;
         end
         S_SORT_STORE: begin
            state_in = dp_status.i_done ? S_SCAN : S_SORT_IW;
         end
         S_SCAN: begin
            if (dp_status.scan_last) state_in = S_SCAN_LAST;
         end
         S_SCAN_LAST: state_in = S_DONE;
         S_DONE:      state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      dp_cmd     = CMD_NONE;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      case (state_ff)
         S_CLEAR: dp_cmd = CMD_CLEAR;
         S_IDLE: begin
            busy = 1'b0;
            if (start) dp_cmd = CMD_LOAD;
         end
         S_EXEC:       dp_cmd = CMD_EXEC;
         S_SORT_I:     dp_cmd = CMD_SORT_I;
         S_SORT_IW:    dp_cmd = CMD_SORT_IW;
         S_SORT_J:     dp_cmd = CMD_SORT_J;
         S_SORT_STORE: dp_cmd = CMD_SORT_STORE;
         S_SCAN:       dp_cmd = CMD_SCAN;
         S_SCAN_LAST:  dp_cmd = CMD_SCAN_LAST;
         S_DONE:       rsp_strobe = 1'b1;
         default:      dp_cmd = CMD_NONE;
      endcase
   end

endmodule

`default_nettype wire

[src/itsmm_dp.sv]
// ============================================================================
// itsmm_dp
// Datapath: entry store, append pointer, sort accumulator, min/max scan and
// result registers.
// ============================================================================
`default_nettype none

module itsmm_dp #(
   parameter int DEPTH = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire itsmm_pkg::dp_cmd_type                dp_cmd,
   output      itsmm_pkg::dp_status_type             dp_status,
   input  wire logic                                 csr_we,
   input  wire logic [itsmm_pkg::LEN_W-1:0]          csr_data,
   input  wire logic [itsmm_pkg::FUNC_W-1:0]         req_func,
   input  wire logic signed [itsmm_pkg::WORD_W-1:0]  req_value,
   input  wire logic [itsmm_pkg::IDX_W-1:0]          req_index,
   output      logic [itsmm_pkg::STAT_W-1:0]         rsp_status,
   output      logic signed [itsmm_pkg::WORD_W-1:0]  rsp_read_value,
   output      logic signed [itsmm_pkg::WORD_W-1:0]  rsp_min_value,
   output      logic signed [itsmm_pkg::WORD_W-1:0]  rsp_max_value,
   output      logic [itsmm_pkg::LEN_W-1:0]          rsp_fill_count
);

   import itsmm_pkg::*;

   localparam int AW   = $clog2(DEPTH);
   localparam int LMAX = (DEPTH < 31) ? DEPTH : 31;
   localparam logic [LEN_W-1:0] LMAX_L   = LEN_W'(LMAX);
   localparam logic [AW-1:0]    CLR_LAST = AW'(DEPTH - 1);

   logic [LEN_W-1:0]         len_ff,    len_in;
   logic [LEN_W-1:0]         append_ff, append_in;
   logic [AW-1:0]            clr_ff,    clr_in;
   logic [FUNC_W-1:0]        func_ff,   func_in;
   logic signed [WORD_W-1:0] value_ff,  value_in;
   logic [IDX_W-1:0]         index_ff,  index_in;
   logic [LEN_W-1:0]         pos_i_ff,  pos_i_in;
   logic [LEN_W-1:0]         pos_j_ff,  pos_j_in;
   logic [LEN_W-1:0]         pos_k_ff,  pos_k_in;
   logic [LEN_W-1:0]         tag_ff,    tag_in;
   logic                     vld_ff,    vld_in;
   logic signed [WORD_W-1:0] acc_ff,    acc_in;
   logic signed [WORD_W-1:0] min_ff,    min_in;
   logic signed [WORD_W-1:0] max_ff,    max_in;
   logic signed [WORD_W-1:0] rd_ff,     rd_in;
   logic [STAT_W-1:0]        status_ff, status_in;

   logic [LEN_W-1:0]         eff_len;
   logic                     idx_ok;
   logic [AW-1:0]            idx_addr;
   logic [LEN_W:0]           i_plus2;

   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic [WORD_W-1:0]        wr_data;
   logic [AW-1:0]            rd_addr;
   logic [WORD_W-1:0]        ram_rd;
   logic signed [WORD_W-1:0] rd_data;

   itsmm_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_rd)
   );

   assign rd_data = $signed(ram_rd);

   always_comb begin
      if (len_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (len_ff > LMAX_L) begin
         eff_len = LMAX_L;
      end else begin
         eff_len = len_ff;
      end
   end

   assign idx_ok   = index_ff < {{(IDX_W-LEN_W){1'b0}}, eff_len};
   assign idx_addr = AW'(index_ff[LEN_W-1:0]);
   assign i_plus2  = {1'b0, pos_i_ff} + (LEN_W+1)'(2);

   assign dp_status.clr_last  = clr_ff == CLR_LAST;
   assign dp_status.sort_go   = (func_ff == FN_SORT) && (eff_len > LEN_W'(1));
   assign dp_status.j_done    = pos_j_ff >= eff_len;
   assign dp_status.i_done    = i_plus2 >= {1'b0, eff_len};
   assign dp_status.scan_last = pos_k_ff == (eff_len - LEN_W'(1));

   always_comb begin
      len_in    = csr_we ? csr_data : len_ff;
      append_in = append_ff;
      clr_in    = clr_ff;
      func_in   = func_ff;
      value_in  = value_ff;
      index_in  = index_ff;
      pos_i_in  = pos_i_ff;
      pos_j_in  = pos_j_ff;
      pos_k_in  = pos_k_ff;
      tag_in    = tag_ff;
      vld_in    = vld_ff;
      acc_in    = acc_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      rd_in     = rd_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = '0;
      rd_addr   = '0;

      case (dp_cmd)
         CMD_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + AW'(1);
         end
         CMD_LOAD: begin
            func_in  = req_func;
            value_in = req_value;
            index_in = req_index;
         end
         CMD_EXEC: begin
            status_in = STAT_OK;
            rd_in     = '0;
            pos_i_in  = '0;
            pos_j_in  = LEN_W'(1);
            pos_k_in  = '0;
            vld_in    = 1'b0;
            case (func_ff)
               FN_APPEND: begin
                  if (append_ff < eff_len) begin
                     wr_en     = 1'b1;
                     wr_addr   = AW'(append_ff);
                     wr_data   = value_ff;
                     append_in = append_ff + LEN_W'(1);
                  end else begin
                     status_in = STAT_FULL;
                  end
               end
               FN_WRITE: begin
                  if (idx_ok) begin
                     wr_en   = 1'b1;
                     wr_addr = idx_addr;
                     wr_data = value_ff;
                  end else begin
                     status_in = STAT_RANGE;
                  end
               end
               FN_CLEAR: begin
                  if (idx_ok) begin
                     wr_en   = 1'b1;
                     wr_addr = idx_addr;
                  end else begin
                     status_in = STAT_RANGE;
                  end
               end
               FN_READ: begin
                  if (!idx_ok) status_in = STAT_RANGE;
               end
               default: status_in = STAT_OK;
            endcase
         end
         CMD_SORT_I: begin
            rd_addr = AW'(pos_i_ff);
         end
         CMD_SORT_IW: begin
            acc_in   = rd_data;
            rd_addr  = AW'(pos_j_ff);
            tag_in   = pos_j_ff;
            pos_j_in = pos_j_ff + LEN_W'(1);
         end
         CMD_SORT_J: begin
            if (rd_data < acc_ff) begin
               wr_en   = 1'b1;
               wr_addr = AW'(tag_ff);
               wr_data = acc_ff;
               acc_in  = rd_data;
            end
            if (!dp_status.j_done) begin
               rd_addr  = AW'(pos_j_ff);
               tag_in   = pos_j_ff;
               pos_j_in = pos_j_ff + LEN_W'(1);
            end
         end
         CMD_SORT_STORE: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(pos_i_ff);
            wr_data  = acc_ff;
            rd_addr  = AW'(pos_i_ff + LEN_W'(1));
            pos_i_in = pos_i_ff + LEN_W'(1);
            pos_j_in = i_plus2[LEN_W-1:0];
         end
         CMD_SCAN, CMD_SCAN_LAST: begin
            if (dp_cmd == CMD_SCAN) begin
               rd_addr  = AW'(pos_k_ff);
               tag_in   = pos_k_ff;
               vld_in   = 1'b1;
               pos_k_in = pos_k_ff + LEN_W'(1);
            end else begin
               vld_in = 1'b0;
            end
            if (vld_ff) begin
               if (tag_ff == '0) begin
                  min_in = rd_data;
                  max_in = rd_data;
               end else begin
                  if (rd_data < min_ff) min_in = rd_data;
                  if (rd_data > max_ff) max_in = rd_data;
               end
               if ((func_ff == FN_READ) && idx_ok &&
                   (index_ff == {{(IDX_W-LEN_W){1'b0}}, tag_ff})) begin
                  rd_in = rd_data;
               end
            end
         end
         default: wr_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= LEN_RESET;
         append_ff <= '0;
         clr_ff    <= '0;
         vld_ff    <= 1'b0;
      end else begin
         len_ff    <= len_in;
         append_ff <= append_in;
         clr_ff    <= clr_in;
         vld_ff    <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      value_ff  <= value_in;
      index_ff  <= index_in;
      pos_i_ff  <= pos_i_in;
      pos_j_ff  <= pos_j_in;
      pos_k_ff  <= pos_k_in;
      tag_ff    <= tag_in;
      acc_ff    <= acc_in;
      min_ff    <= min_in;
      max_ff    <= max_in;
      rd_ff     <= rd_in;
      status_ff <= status_in;
   end

   assign rsp_status     = status_ff;
   assign rsp_read_value = rd_ff;
   assign rsp_min_value  = min_ff;
   assign rsp_max_value  = max_ff;
   assign rsp_fill_count = append_ff;

endmodule

`default_nettype wire

[src/int_table_with_sort_min_max.sv]
// ============================================================================
// int_table_with_sort_min_max
// Table of signed 32-bit words with append pointer, exchange sort and
// min/max over the used length.
//
//   channel   ports                         handshake
//   request   req_func req_value req_index  start & !busy
//   response  rsp_status rsp_read_value     rsp_strobe, one cycle, no stall
//             rsp_min_value rsp_max_value
//             rsp_fill_count
//   config    csr_used_length               csr_valid & csr_ready
//
// Every item ends with a min/max scan over the L used entries (L = used length);
// a sort item with L >= 2 runs the exchange loops first, with one RAM read
// port and one compare-exchange per cycle.
// After reset a clearing pass writes zero to all DEPTH entries, one per
// cycle, with busy high. The response cannot be stalled.
// ============================================================================
`default_nettype none

module int_table_with_sort_min_max #(
   parameter int DEPTH = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output      logic                                 busy,
   input  wire logic [itsmm_pkg::FUNC_W-1:0]         req_func,
   input  wire logic signed [itsmm_pkg::WORD_W-1:0]  req_value,
   input  wire logic [itsmm_pkg::IDX_W-1:0]          req_index,
   output      logic                                 rsp_strobe,
   output      logic [itsmm_pkg::STAT_W-1:0]         rsp_status,
   output      logic signed [itsmm_pkg::WORD_W-1:0]  rsp_read_value,
   output      logic signed [itsmm_pkg::WORD_W-1:0]  rsp_min_value,
   output      logic signed [itsmm_pkg::WORD_W-1:0]  rsp_max_value,
   output      logic [itsmm_pkg::LEN_W-1:0]          rsp_fill_count,
   input  wire logic                                 csr_valid,
   output      logic                                 csr_ready,
   input  wire logic [itsmm_pkg::LEN_W-1:0]          csr_used_length
);

   import itsmm_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   assign csr_ready = 1'b1;

   itsmm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .dp_status  (dp_status),
      .dp_cmd     (dp_cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   itsmm_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .dp_cmd         (dp_cmd),
      .dp_status      (dp_status),
      .csr_we         (csr_valid & csr_ready),
      .csr_data       (csr_used_length),
      .req_func       (req_func),
      .req_value      (req_value),
      .req_index      (req_index),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value),
      .rsp_min_value  (rsp_min_value),
      .rsp_max_value  (rsp_max_value),
      .rsp_fill_count (rsp_fill_count)
   );

endmodule

`default_nettype wire

[tb/tb_int_table_with_sort_min_max.sv]
// ============================================================================
// tb_int_table_with_sort_min_max
// Self-checking bench for the integer table with exchange sort and min/max.
// A shadow copy of the table, append pointer and used length predicts every
// response. Directed items cover value extremes, full and out-of-range cases,
// spare selectors and length clamping. A long random run then follows, spread
// over many length settings with random sender gaps.
// ============================================================================
`default_nettype none

module tb_int_table_with_sort_min_max;

   import itsmm_pkg::*;

   localparam int DEPTH        = 16;
   localparam int RANDOM_ITEMS = 1750;
   localparam int STALL_LIMIT  = 2000;
   localparam int SETTLE_WAIT  = 200;

   localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd5;
   localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

   typedef struct {
      logic [STAT_W-1:0]        status;
      logic signed [WORD_W-1:0] read_value;
      logic signed [WORD_W-1:0] min_value;
      logic signed [WORD_W-1:0] max_value;
      logic [LEN_W-1:0]         fill_count;
   } table_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic [FUNC_W-1:0]        req_func = '0;
   logic signed [WORD_W-1:0] req_value = '0;
   logic [IDX_W-1:0]         req_index = '0;
   logic                     csr_valid = 1'b0;
   logic [LEN_W-1:0]         csr_used_length = '0;

   logic                     busy;
   logic                     rsp_strobe;
   logic [STAT_W-1:0]        rsp_status;
   logic signed [WORD_W-1:0] rsp_read_value;
   logic signed [WORD_W-1:0] rsp_min_value;
   logic signed [WORD_W-1:0] rsp_max_value;
   logic [LEN_W-1:0]         rsp_fill_count;
   logic                     csr_ready;

   logic signed [WORD_W-1:0] shadow_words [DEPTH];
   logic [LEN_W-1:0]         fill_ptr;
   logic [LEN_W-1:0]         length_reg;

   table_result_type pending_results [$];
   int               mismatches = 0;
   int               idle_cycles = 0;
   bit               gaps_off = 1'b0;

   int_table_with_sort_min_max #(
      .DEPTH(DEPTH)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_value      (req_value),
      .req_index      (req_index),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value),
      .rsp_min_value  (rsp_min_value),
      .rsp_max_value  (rsp_max_value),
      .rsp_fill_count (rsp_fill_count),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_used_length(csr_used_length)
   );

   always #2 clock = ~clock;

   function automatic int used_count();
      if (length_reg == 0) return 1;
      if (length_reg > DEPTH) return DEPTH;
      return int'(length_reg);
   endfunction

   function automatic table_result_type apply_table_op(input logic [FUNC_W-1:0] f,
                                                       input logic signed [WORD_W-1:0] v,
                                                       input logic [IDX_W-1:0] idx);
      table_result_type         r;
      int                       n;
      logic signed [WORD_W-1:0] t;
      n = used_count();
      r.status = STAT_OK;
      r.read_value = '0;
      case (f)
         FN_APPEND: begin
            if (fill_ptr < n) begin
               shadow_words[fill_ptr] = v;
               fill_ptr++;
            end else begin
               r.status = STAT_FULL;
            end
         end
         FN_WRITE: begin
            if (idx < n) shadow_words[idx] = v;
            else r.status = STAT_RANGE;
         end
         FN_CLEAR: begin
            if (idx < n) shadow_words[idx] = '0;
            else r.status = STAT_RANGE;
         end
         FN_SORT: begin
            for (int i = 0; i < n - 1; i++) begin
               for (int j = i + 1; j < n; j++) begin
                  if (shadow_words[j] < shadow_words[i]) begin
                     t = shadow_words[i];
                     shadow_words[i] = shadow_words[j];
                     shadow_words[j] = t;
                  end
               end
            end
         end
         FN_READ: begin
            if (idx < n) r.read_value = shadow_words[idx];
            else r.status = STAT_RANGE;
         end
         default: ;
      endcase
      r.min_value = shadow_words[0];
      r.max_value = shadow_words[0];
      for (int i = 1; i < n; i++) begin
         if (shadow_words[i] < r.min_value) r.min_value = shadow_words[i];
         if (shadow_words[i] > r.max_value) r.max_value = shadow_words[i];
      end
      r.fill_count = fill_ptr;
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (gaps_off || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic signed [WORD_W-1:0] pick_word();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 32'sh7FFF_FFFF;
      if (r == 1) return 32'sh8000_0000;
      if (r == 2) return $signed($urandom_range(0, 20)) - 10;
      return $urandom();
   endfunction

   function automatic logic [IDX_W-1:0] pick_index();
      if ($urandom_range(0, 4) == 0) return IDX_W'($urandom_range(0, 255));
      return IDX_W'($urandom_range(0, used_count()));
   endfunction

   function automatic logic [FUNC_W-1:0] pick_func();
      int r;
      r = $urandom_range(0, 99);
      if (r < 24) return FN_APPEND;
      if (r < 44) return FN_WRITE;
      if (r < 54) return FN_CLEAR;
      if (r < 62) return FN_SORT;
      if (r < 94) return FN_READ;
      return FUNC_W'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
   endfunction

   task automatic send_item(input logic [FUNC_W-1:0] f, input logic signed [WORD_W-1:0] v,
                            input logic [IDX_W-1:0] idx);
      int gap;
      start     <= 1'b1;
      req_func  <= f;
      req_value <= v;
      req_index <= idx;
      do @(posedge clock); while (busy);
      pending_results.push_back(apply_table_op(f, v, idx));
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_all_results();
      start <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic write_length(input logic [LEN_W-1:0] len);
      wait_all_results();
      csr_valid       <= 1'b1;
      csr_used_length <= len;
      do @(posedge clock); while (!csr_ready);
      length_reg = len;
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_state();
      send_item(FN_READ, 0, 0);
      send_item(FN_READ, 0, IDX_W'(DEPTH - 1));
      send_item(FN_READ, 0, IDX_W'(DEPTH));
   endtask

   task automatic test_append_full();
      write_length(4);
      send_item(FN_APPEND, 32'sh7FFF_FFFF, 0);
      send_item(FN_APPEND, 32'sh8000_0000, 0);
      send_item(FN_APPEND, -1, 0);
      send_item(FN_APPEND, 0, 0);
      send_item(FN_APPEND, 5, 0);
      // pointer now above the used length
      write_length(2);
      send_item(FN_APPEND, 7, 0);
   endtask

   task automatic test_index_ops();
      write_length(LEN_W'(DEPTH));
      send_item(FN_WRITE, 123, IDX_W'(DEPTH - 1));
      send_item(FN_WRITE, 456, IDX_W'(DEPTH));
      send_item(FN_WRITE, 789, 8'hFF);
      send_item(FN_CLEAR, 0, 1);
      send_item(FN_CLEAR, 0, IDX_W'(DEPTH));
      send_item(FN_READ, 0, IDX_W'(DEPTH - 1));
      send_item(FN_READ, 0, 8'hFF);
      for (int f = FN_SPARE_LO; f <= FN_SPARE_HI; f++) send_item(f[FUNC_W-1:0], -5, 0);
   endtask

   task automatic test_sort();
      send_item(FN_SORT, 0, 0);
      send_item(FN_READ, 0, 0);
      wait_all_results();
      send_item(FN_SORT, 0, 0);
   endtask

   task automatic test_length_clamp();
      write_length(0);
      send_item(FN_READ, 0, 0);
      send_item(FN_READ, 0, 1);
      write_length(31);
      send_item(FN_READ, 0, IDX_W'(DEPTH - 1));
      write_length(17);
      send_item(FN_SORT, 0, 0);
   endtask

   task automatic test_random();
      int sent;
      int phase;
      int burst;
      int ramp [5] = '{1, 2, 4, 8, 16};
      int edges [5] = '{0, 1, 16, 17, 31};
      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         if (phase < 5) write_length(LEN_W'(ramp[phase]));
         else if (phase % 4 == 0) write_length(LEN_W'(edges[$urandom_range(0, 4)]));
         else write_length(LEN_W'($urandom_range(0, 31)));
         gaps_off = ($urandom_range(0, 3) == 0);
         burst = $urandom_range(40, 160);
         for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
            send_item(pick_func(), pick_word(), pick_index());
            sent++;
         end
         phase++;
      end
      gaps_off = 1'b0;
   endtask

   always @(posedge clock) begin : result_check
      table_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            $error("result with no pending item: status %0d", rsp_status);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("rsp_status: expected %0d, got %0d", want.status, rsp_status);
               mismatches++;
            end
            if (rsp_read_value !== want.read_value) begin
               $error("rsp_read_value: expected %0d, got %0d", want.read_value,
                      rsp_read_value);
               mismatches++;
            end
            if (rsp_min_value !== want.min_value) begin
               $error("rsp_min_value: expected %0d, got %0d", want.min_value, rsp_min_value);
               mismatches++;
            end
            if (rsp_max_value !== want.max_value) begin
               $error("rsp_max_value: expected %0d, got %0d", want.max_value, rsp_max_value);
               mismatches++;
            end
            if (rsp_fill_count !== want.fill_count) begin
               $error("rsp_fill_count: expected %0d, got %0d", want.fill_count,
                      rsp_fill_count);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < DEPTH; i++) shadow_words[i] = '0;
      fill_ptr   = '0;
      length_reg = LEN_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_append_full();
      test_index_ops();
      test_sort();
      test_length_clamp();
      test_random();
      wait_all_results();
      repeat (SETTLE_WAIT) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

[filelist.f]
src/itsmm_pkg.sv
src/itsmm_ram.sv
src/itsmm_ctrl.sv
src/itsmm_dp.sv
src/int_table_with_sort_min_max.sv
tb/tb_int_table_with_sort_min_max.sv
